/* rtl/circular_deque_top_assert.svh */
// Assertion macros for the circular deque top level.
// Clocked on aclk, gated off while aresetn is low; empty when SYNTHESIS is set.
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define CDQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deque assertion failed (same cycle)");

`define CDQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deque assertion failed (next cycle)");

`else

`define CDQ_ASSERT_IMP(lbl, ante, cons)

`define CDQ_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* rtl/cdq_pkg.sv */
// Shared constants, codes and types for the circular deque.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int SIZE_W   = 7;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [SIZE_W-1:0] QUEUE_SIZE_RST = 7'd64;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST_FWD   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LIST_BWD   = 3'd5;

    // result status
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } cdq_state_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                last;
    } cdq_res_t;

    // size in use: zero acts as one, anything above the capacity as the capacity
    function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] s,
                                                     input logic [SIZE_W-1:0] cap);
        logic [SIZE_W-1:0] r;
        r = s;
        if (r == '0) begin
            r = SIZE_W'(1);
        end
        if (r > cap) begin
            r = cap;
        end
        return r;
    endfunction

endpackage

/* rtl/circular_deque_top.sv */
// Circular deque: a double-ended queue kept in a ring of RAM slots.
//
// Input stream s_*: one request word per handshake; s_tuser carries the
// request kind (push front/rear, pop front/rear, list forward/backward),
// s_tdata the value to push. Output stream m_*: result words; m_tuser is
// the status (done, full, empty), m_tdata the popped or listed element,
// m_tlast marks the final word of a request.
// Ring size is set through cfg_we/cfg_wdata; write it only while idle and
// empty. Zero acts as one, values above the capacity as the capacity.
// Push and refusals: result is registered at the accept edge, visible the
// next cycle; one request per cycle when the sink keeps up.
// Pop: slot read is registered; a new request waits until the pop is done.
// List of N elements: one word per cycle after the first read while the sink
// keeps up, paced by the single RAM read port.
// Reset (aresetn low, synchronous) empties the deque and sets size 64; no
// clearing pass, slots are undefined until pushed.
// When m_tready is low the output word holds, the list pauses and
// s_tready stays low until the output register frees up.
// Depends on cdq_pkg, cdq_ctrl, cdq_ram and circular_deque_top_assert.svh.
`timescale 1ns / 1ps
`include "circular_deque_top_assert.svh"

module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0]  s_tdata,   // value
    input  logic [KIND_W-1:0]                      s_tuser,   // kind
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((DATA_WIDTH + 7) / 8) * 8-1:0]  m_tdata,   // element
    output logic [STATUS_W-1:0]                    m_tuser,   // status
    output logic                                   m_tlast,
    input  logic                                   cfg_we,
    input  logic [SIZE_W-1:0]                      cfg_wdata
);

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [SIZE_W-1:0]     size_use;
    logic                  mvalid_reg, mvalid_next;
    logic [DATA_WIDTH-1:0] elem_reg, elem_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  last_reg, last_next;
    logic                  out_free;

    cdq_res_t              res;
    logic [DATA_WIDTH-1:0] res_element;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    assign size_use = size_clamp(size_reg, SIZE_W'(CAPACITY));
    assign out_free = !mvalid_reg || m_tready;

    cdq_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_kind      (s_tuser),
        .s_value     (s_tdata[DATA_WIDTH-1:0]),
        .size_use    (size_use),
        .out_free    (out_free),
        .res         (res),
        .res_element (res_element),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    cdq_ram #(
        .DEPTH      (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        size_next   = cfg_we ? cfg_wdata : size_reg;
        mvalid_next = mvalid_reg && !m_tready;
        elem_next   = elem_reg;
        status_next = status_reg;
        last_next   = last_reg;
        if (res.valid) begin
            mvalid_next = 1'b1;
            elem_next   = res_element;
            status_next = res.status;
            last_next   = res.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg   <= QUEUE_SIZE_RST;
            mvalid_reg <= 1'b0;
        end else begin
            size_reg   <= size_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elem_reg   <= elem_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = TDATA_W'(elem_reg);
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    `CDQ_ASSERT_IMP(a_no_overwrite, res.valid, !mvalid_reg || m_tready)
    `CDQ_ASSERT_IMP(a_busy_when_held, mvalid_reg && !m_tready, !s_tready)
    `CDQ_ASSERT_IMP(a_refusal_shape, m_tvalid && (m_tuser != STAT_DONE),
                    m_tlast && (elem_reg == '0))
    `CDQ_ASSERT_NXT(a_pop_goes_busy,
                    s_tvalid && s_tready && !res.valid &&
                    ((s_tuser == KIND_POP_FRONT) || (s_tuser == KIND_POP_REAR)),
                    !s_tready)

endmodule

/* rtl/cdq_ram.sv */
// Slot storage of the deque: one write port, one read port, registered read.
// Depends on cdq_pkg for its default depth and data width.
`timescale 1ns / 1ps

module cdq_ram
    import cdq_pkg::*;
#(
    parameter int DEPTH      = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ADDR_W     = 6
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/cdq_ctrl.sv */
// Request sequencer of the deque: head/tail/empty state, push writes,
// pop and list reads out of cdq_ram. Uses cdq_pkg codes and types.
`timescale 1ns / 1ps

module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX_W      = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [KIND_W-1:0]            s_kind,
    input  logic signed [DATA_WIDTH-1:0] s_value,
    input  logic [SIZE_W-1:0]            size_use,
    input  logic                         out_free,
    output cdq_res_t                     res,
    output logic [DATA_WIDTH-1:0]        res_element,
    output logic                         ram_we,
    output logic [IDX_W-1:0]             ram_waddr,
    output logic [DATA_WIDTH-1:0]        ram_wdata,
    output logic [IDX_W-1:0]             ram_raddr,
    input  logic [DATA_WIDTH-1:0]        ram_rdata
);

    cdq_state_t state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic              empty_reg, empty_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  stop_reg, stop_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic              single_reg, single_next;
    logic              fwd_reg, fwd_next;

    logic             acc;
    logic             full;
    logic             rear_side;
    logic             fin;
    logic [IDX_W-1:0] fw_head, fw_tail, bk_head, bk_tail, ptr_adv;

    function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i,
                                                  input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] nx;
        nx = SIZE_W'(i) + SIZE_W'(1);
        return (nx >= sz) ? '0 : IDX_W'(nx);
    endfunction

    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i,
                                                   input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] pv;
        pv = sz - SIZE_W'(1);
        return (i == '0) ? IDX_W'(pv) : i - IDX_W'(1);
    endfunction

    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign acc       = s_valid && s_ready;
    assign fw_head   = step_fwd(head_reg, size_use);
    assign fw_tail   = step_fwd(tail_reg, size_use);
    assign bk_head   = step_back(head_reg, size_use);
    assign bk_tail   = step_back(tail_reg, size_use);
    assign ptr_adv   = fwd_reg ? step_fwd(ptr_reg, size_use) : step_back(ptr_reg, size_use);
    assign full      = !empty_reg && (fw_tail == head_reg);
    assign rear_side = (s_kind == KIND_POP_REAR) || (s_kind == KIND_LIST_BWD);
    assign fin       = single_reg || (ptr_reg == stop_reg) ||
                       ((cnt_reg + SIZE_W'(1)) >= size_use);
    assign ram_wdata = s_value;

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        ptr_next    = ptr_reg;
        stop_next   = stop_reg;
        cnt_next    = cnt_reg;
        single_next = single_reg;
        fwd_next    = fwd_reg;
        res         = '0;
        res_element = '0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_raddr   = ptr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // read is launched in the accept cycle, data arrives in ST_RUN
                ram_raddr = rear_side ? tail_reg : head_reg;
                if (acc) begin
                    unique case (s_kind)
                        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                            res.valid = 1'b1;
                            res.last  = 1'b1;
                            if (full) begin
                                res.status = STAT_FULL;
                            end else begin
                                res.status = STAT_DONE;
                                ram_we     = 1'b1;
                                empty_next = 1'b0;
                                if (empty_reg) begin
                                    head_next = '0;
                                    tail_next = '0;
                                    ram_waddr = '0;
                                end else if (s_kind == KIND_PUSH_FRONT) begin
                                    head_next = bk_head;
                                    ram_waddr = bk_head;
                                end else begin
                                    tail_next = fw_tail;
                                    ram_waddr = fw_tail;
                                end
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_REAR, KIND_LIST_FWD, KIND_LIST_BWD: begin
                            if (empty_reg) begin
                                res.valid  = 1'b1;
                                res.last   = 1'b1;
                                res.status = STAT_EMPTY;
                            end else begin
                                state_next  = ST_RUN;
                                ptr_next    = rear_side ? tail_reg : head_reg;
                                stop_next   = rear_side ? head_reg : tail_reg;
                                cnt_next    = '0;
                                single_next = (s_kind == KIND_POP_FRONT) ||
                                              (s_kind == KIND_POP_REAR);
                                fwd_next    = !rear_side;
                                // pops retire the index now; the read uses the old one
                                if (s_kind == KIND_POP_FRONT || s_kind == KIND_POP_REAR) begin
                                    if (head_reg == tail_reg) begin
                                        empty_next = 1'b1;
                                        head_next  = '0;
                                        tail_next  = '0;
                                    end else if (s_kind == KIND_POP_FRONT) begin
                                        head_next = fw_head;
                                    end else begin
                                        tail_next = bk_tail;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                // stalled: keep re-reading ptr_reg so the read data holds
                if (out_free) begin
                    res.valid   = 1'b1;
                    res.status  = STAT_DONE;
                    res.last    = fin;
                    res_element = ram_rdata;
                    if (fin) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next  = ptr_adv;
                        cnt_next  = cnt_reg + SIZE_W'(1);
                        ram_raddr = ptr_adv;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        stop_reg   <= stop_next;
        cnt_reg    <= cnt_next;
        single_reg <= single_next;
        fwd_reg    <= fwd_next;
    end

endmodule
